[src/srat_pkg.sv]
// Shared types and constants for the segment range address translator.
package srat_pkg;

  localparam int unsigned AddrW = 64;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_V2F     = 2'd1,
    CMD_F2V     = 2'd2,
    CMD_MAXIMA  = 2'd3
  } cmd_e;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NOMATCH = 2'd1;
  localparam logic [1:0] STATUS_BSS     = 2'd2;

  localparam logic CFG_SEG_COUNT  = 1'b0;
  localparam logic CFG_IMAGE_SIZE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic             is_load;
    logic [AddrW-1:0] vaddr;
    logic [AddrW-1:0] memsz;
    logic [AddrW-1:0] offset;
    logic [AddrW-1:0] filesz;
  } seg_entry_t;

  localparam int unsigned EntryW = $bits(seg_entry_t);

  typedef struct packed {
    logic [1:0]       status;
    logic [AddrW-1:0] translated;
    logic [AddrW-1:0] file_end_max;
    logic [AddrW-1:0] vaddr_end_max;
  } result_t;

endpackage

[src/segment_range_address_translator.sv]
// Segment range address translator: top level with config, segment RAM and output beat register.
//
// Input channel (in_valid_i/in_ready_o) carries one command beat: write an entry,
// translate virtual to file offset, translate file offset to virtual, or report maxima.
// Output channel (out_valid_o/out_ready_i) returns exactly one result beat per command.
// Config port: cfg_we_i writes segment_count (index 0) or image_size (index 1) at once.
// An entry write's result passes from the sequencer's finish state into the output register.
// A query or maxima command scans the live entries in index order, one RAM read per
// cycle; a query stops at its first hit, and with no live entries the scan is skipped.
// The single read port of the segment RAM sets that rate.
// Only one command is in flight at a time; in_ready_o rises again once the result has
// moved into the output register, so a new beat is taken while an old one still waits.
// If the receiver stalls, the finished result is held in the sequencer and no new beat
// is accepted until the output register frees up.
// Reset clears control state, segment_count and image_size; table entries are undefined
// until written.
module segment_range_address_translator #(
  parameter int unsigned MAX_SEGMENTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [3:0]  entry_index_i,
  input  logic        entry_is_load_i,
  input  logic [63:0] entry_vaddr_i,
  input  logic [63:0] entry_memsz_i,
  input  logic [63:0] entry_offset_i,
  input  logic [63:0] entry_filesz_i,
  input  logic [63:0] query_addr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] translated_o,
  output logic [63:0] file_end_max_o,
  output logic [63:0] vaddr_end_max_o
);
  import srat_pkg::*;

  localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  logic [4:0]  seg_count_q;
  logic [63:0] image_size_q;
  logic        out_valid_q, out_valid_d;
  result_t     out_q;

  logic        eng_ready, eng_start, res_valid, res_take;
  result_t     res;
  logic        ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  seg_entry_t  ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q  <= '0;
      image_size_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SEG_COUNT) begin
        seg_count_q <= cfg_wdata_i[4:0];
      end
      if (cfg_idx_i == CFG_IMAGE_SIZE) begin
        image_size_q <= cfg_wdata_i;
      end
    end
  end

  assign eng_start = in_valid_i && eng_ready;
  assign in_ready_o = eng_ready;
  assign res_take  = res_valid && (!out_valid_q || out_ready_i);
  assign out_valid_d = res_take || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  srat_engine #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .AW(AW)
  ) u_engine (
    .clk_i,
    .rst_ni,
    .start_i        (eng_start),
    .ready_o        (eng_ready),
    .cmd_i,
    .entry_index_i,
    .entry_is_load_i,
    .entry_vaddr_i,
    .entry_memsz_i,
    .entry_offset_i,
    .entry_filesz_i,
    .query_addr_i,
    .seg_count_i    (seg_count_q),
    .image_size_i   (image_size_q),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .res_take_i     (res_take)
  );

  srat_ram #(
    .Width(EntryW),
    .Depth(MAX_SEGMENTS),
    .AddrW(AW)
  ) u_seg_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign translated_o    = out_q.translated;
  assign file_end_max_o  = out_q.file_end_max;
  assign vaddr_end_max_o = out_q.vaddr_end_max;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_start |=> !in_ready_o)
    else $error("second command taken while one is in flight");

  a_take_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |=> out_valid_o && in_ready_o)
    else $error("result move did not free the sequencer");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !res_take)
    else $error("stalled output beat overwritten");

endmodule

[src/srat_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module srat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/srat_engine.sv]
// Command sequencer: table writes and one-entry-per-cycle scans over the segment RAM.
module srat_engine #(
  parameter int unsigned MAX_SEGMENTS = 16,
  parameter int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    ready_o,
  input  logic [1:0]              cmd_i,
  input  logic [3:0]              entry_index_i,
  input  logic                    entry_is_load_i,
  input  logic [63:0]             entry_vaddr_i,
  input  logic [63:0]             entry_memsz_i,
  input  logic [63:0]             entry_offset_i,
  input  logic [63:0]             entry_filesz_i,
  input  logic [63:0]             query_addr_i,
  input  logic [4:0]              seg_count_i,
  input  logic [63:0]             image_size_i,
  output logic                    ram_we_o,
  output logic [AW-1:0]           ram_waddr_o,
  output srat_pkg::seg_entry_t    ram_wdata_o,
  output logic                    ram_re_o,
  output logic [AW-1:0]           ram_raddr_o,
  input  srat_pkg::seg_entry_t    ram_rdata_i,
  output logic                    res_valid_o,
  output srat_pkg::result_t       res_o,
  input  logic                    res_take_i
);
  import srat_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned CmpW = (CntW > 5) ? CntW : 5;
  localparam int unsigned EidW = (CntW > 4) ? CntW : 4;

  state_e            state_q, state_d;
  logic [1:0]        cmd_q, cmd_d;
  logic [AddrW-1:0]  q_q, q_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   issue_q, issue_d;
  logic              rvld_q, rvld_d;
  result_t           res_q, res_d;

  logic [CntW-1:0]   live_cnt;
  logic              idx_ok;
  logic              is_v2f;
  logic [AddrW-1:0]  rng_start, rng_size, rng_base, rng_end, delta, tr_new;
  logic [AddrW-1:0]  fe, ve;
  logic              in_rng, bss, last;

  assign live_cnt = (CmpW'(seg_count_i) > CmpW'(MAX_SEGMENTS))
                    ? CntW'(MAX_SEGMENTS) : CntW'(seg_count_i);
  assign idx_ok   = EidW'(entry_index_i) < EidW'(MAX_SEGMENTS);

  // Per-entry evaluation on the registered read data
  assign is_v2f    = (cmd_q == CMD_V2F);
  assign rng_start = is_v2f ? ram_rdata_i.vaddr  : ram_rdata_i.offset;
  assign rng_size  = is_v2f ? ram_rdata_i.memsz  : ram_rdata_i.filesz;
  assign rng_base  = is_v2f ? ram_rdata_i.offset : ram_rdata_i.vaddr;
  assign rng_end   = rng_start + rng_size;
  assign delta     = q_q - rng_start;
  assign tr_new    = rng_base + delta;
  assign in_rng    = ram_rdata_i.is_load && (rng_size != '0)
                     && (q_q >= rng_start) && (q_q < rng_end);
  assign bss       = is_v2f && (delta >= ram_rdata_i.filesz);
  assign fe        = ram_rdata_i.offset + ram_rdata_i.filesz;
  assign ve        = ram_rdata_i.vaddr + ram_rdata_i.memsz;
  assign last      = (issue_q == cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      issue_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      issue_q <= issue_d;
      rvld_q  <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    q_q   <= q_d;
    res_q <= res_d;
  end

  // Writes happen only on accept in idle, scans only afterwards: no overlap on an entry.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    q_d         = q_q;
    cnt_d       = cnt_q;
    issue_d     = issue_q;
    rvld_d      = 1'b0;
    res_d       = res_q;
    ready_o     = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = issue_q[AW-1:0];
    ram_waddr_o = AW'(entry_index_i);
    ram_wdata_o = '{is_load: entry_is_load_i, vaddr: entry_vaddr_i, memsz: entry_memsz_i,
                    offset: entry_offset_i, filesz: entry_filesz_i};
    unique case (state_q)
      ST_IDLE: begin
        ready_o = 1'b1;
        if (start_i) begin
          cmd_d   = cmd_i;
          q_d     = query_addr_i;
          cnt_d   = live_cnt;
          issue_d = '0;
          res_d   = '0;
          if (cmd_i == CMD_V2F || cmd_i == CMD_F2V) begin
            res_d.status = STATUS_NOMATCH;
          end
          if (cmd_i == CMD_MAXIMA) begin
            res_d.file_end_max = image_size_i;
          end
          if (cmd_i == CMD_WRITE) begin
            ram_we_o = idx_ok;
            state_d  = ST_FINISH;
          end else if (live_cnt == '0) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue_q < cnt_q) begin
          ram_re_o = 1'b1;
          issue_d  = issue_q + 1'b1;
          rvld_d   = 1'b1;
        end
        if (rvld_q) begin
          if (cmd_q == CMD_MAXIMA) begin
            if (ram_rdata_i.is_load && (fe > res_q.file_end_max)) begin
              res_d.file_end_max = fe;
            end
            if (ram_rdata_i.is_load && (ve > res_q.vaddr_end_max)) begin
              res_d.vaddr_end_max = ve;
            end
            if (last) begin
              state_d = ST_FINISH;
              rvld_d  = 1'b0;
            end
          end else if (in_rng) begin
            res_d.status     = bss ? STATUS_BSS : STATUS_OK;
            res_d.translated = bss ? '0 : tr_new;
            state_d          = ST_FINISH;
            rvld_d           = 1'b0;
          end else if (last) begin
            state_d = ST_FINISH;
            rvld_d  = 1'b0;
          end
        end
      end
      ST_FINISH: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> issue_q <= cnt_q)
    else $error("scan issued past the live count");

  a_rvld_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvld_q |-> state_q == ST_SCAN)
    else $error("read data flagged outside a scan");

  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> cmd_q != CMD_WRITE)
    else $error("write command entered a scan");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH |-> res_q.status <= STATUS_BSS)
    else $error("illegal status code");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_SCAN) |-> cnt_q != '0)
    else $error("scan started with no live entries");

endmodule
